// ===== design/lsep_pkg.sv =====
package lsep_pkg;

  localparam int SAMPLE_W = 14;
  localparam int REF_W    = 14;
  localparam int N_W      = 4;
  localparam int PFX_W    = 12;
  localparam int CW_W     = 26;
  localparam int LEN_W    = 5;
  localparam int PEND_W   = 7;
  localparam int ACC_W    = 33;
  localparam int CNT_W    = 6;
  localparam int BYTE_W   = 8;

  typedef struct packed {
    logic [CW_W-1:0]  cw;
    logic [LEN_W-1:0] cw_len;
    logic             last;
  } lsep_code_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } lsep_q_stat_t;

  function automatic logic [PFX_W-1:0] prefix_code(input logic [N_W-1:0] n);
    logic [PFX_W-1:0] c;
    unique case (n)
      4'd0:    c = 12'h000;
      4'd1:    c = 12'h002;
      4'd2:    c = 12'h003;
      4'd3:    c = 12'h004;
      4'd4:    c = 12'h005;
      4'd5:    c = 12'h006;
      4'd6:    c = 12'h00E;
      4'd7:    c = 12'h01E;
      4'd8:    c = 12'h03E;
      4'd9:    c = 12'h07E;
      4'd10:   c = 12'h0FE;
      4'd11:   c = 12'h1FE;
      4'd12:   c = 12'h3FE;
      4'd13:   c = 12'h7FE;
      4'd14:   c = 12'hFFE;
      default: c = 12'h000;
    endcase
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] prefix_len(input logic [N_W-1:0] n);
    logic [LEN_W-1:0] l;
    unique case (n)
      4'd0:    l = 5'd2;
      4'd1:    l = 5'd3;
      4'd2:    l = 5'd3;
      4'd3:    l = 5'd3;
      4'd4:    l = 5'd3;
      4'd5:    l = 5'd3;
      4'd6:    l = 5'd4;
      4'd7:    l = 5'd5;
      4'd8:    l = 5'd6;
      4'd9:    l = 5'd7;
      4'd10:   l = 5'd8;
      4'd11:   l = 5'd9;
      4'd12:   l = 5'd10;
      4'd13:   l = 5'd11;
      4'd14:   l = 5'd12;
      default: l = 5'd2;
    endcase
    return l;
  endfunction

endpackage

// ===== design/lsep_ifs.sv =====
interface lsep_in_if;
  logic                          valid;
  logic                          ready;
  logic [lsep_pkg::SAMPLE_W-1:0] sample;
  logic                          last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface lsep_out_if;
  logic                        valid;
  logic                        ready;
  logic [lsep_pkg::BYTE_W-1:0] packed_byte;
  logic                        run_end;
  logic                        block_end;

  modport source (output valid, packed_byte, run_end, block_end, input ready);
  modport sink   (input valid, packed_byte, run_end, block_end, output ready);
endinterface

// ===== design/lsep_front.sv =====
module lsep_front #(
  parameter int SAMPLE_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lsep_pkg::REF_W-1:0] init_ref,
  lsep_in_if.sink                    in_if,
  input  lsep_pkg::lsep_q_stat_t     q_stat,
  output logic                       push,
  output lsep_pkg::lsep_code_t       push_data
);
  import lsep_pkg::*;

  logic [SAMPLE_BITS-1:0] prev_r;
  logic                   first_r;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] ref_val;
  logic [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]   diff_neg;
  logic [SAMPLE_BITS:0]   diff_m1;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] sfx_src;
  logic [N_W-1:0]         n;
  logic [SAMPLE_W-1:0]    sfx_mask;
  logic [SAMPLE_W-1:0]    sfx;

  assign in_if.ready = !q_stat.full;
  assign push        = in_if.valid && in_if.ready;

  always_comb begin
    smp      = in_if.sample[SAMPLE_BITS-1:0];
    ref_val  = first_r ? init_ref[SAMPLE_BITS-1:0] : prev_r;
    diff     = {1'b0, smp} - {1'b0, ref_val};
    diff_neg = -diff;
    diff_m1  = diff - (SAMPLE_BITS+1)'(1);
    mag      = diff[SAMPLE_BITS] ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
    sfx_src  = diff[SAMPLE_BITS] ? diff_m1[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
    n = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (mag[i]) begin
        n = N_W'(i + 1);
      end
    end
    sfx_mask = (SAMPLE_W'(1) << n) - SAMPLE_W'(1);
    sfx      = SAMPLE_W'(sfx_src) & sfx_mask;
    push_data.cw     = (CW_W'(prefix_code(n)) << n) | CW_W'(sfx);
    push_data.cw_len = prefix_len(n) + LEN_W'(n);
    push_data.last   = in_if.last_sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (push) begin
      first_r <= in_if.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      prev_r <= smp;
    end
  end

endmodule

// ===== design/lsep_queue.sv =====
module lsep_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  lsep_pkg::lsep_code_t   push_data,
  input  logic                   pop,
  output lsep_pkg::lsep_code_t   pop_data,
  output lsep_pkg::lsep_q_stat_t stat
);
  import lsep_pkg::*;

  lsep_code_t  slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign pop_data      = slot_r[rd_ptr_r];
  assign stat.full     = count_r == 2'd2;
  assign stat.nonempty = count_r != 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/lsep_back.sv =====
module lsep_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lsep_pkg::lsep_q_stat_t q_stat,
  input  lsep_pkg::lsep_code_t   q_data,
  output logic                   pop,
  lsep_out_if.source             out_if
);
  import lsep_pkg::*;

  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    last_r, last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]       byte_r, byte_nxt;
  logic                    run_end_r, run_end_nxt;
  logic                    block_end_r, block_end_nxt;
  logic                    emittable;
  logic                    slot_free;
  logic                    emit;
  logic [CNT_W-1:0]        rem;
  logic                    rem_emittable;
  logic [ACC_W+BYTE_W-1:0] window;
  logic [PEND_W-1:0]       pend;

  assign out_if.valid       = out_valid_r;
  assign out_if.packed_byte = byte_r;
  assign out_if.run_end     = run_end_r;
  assign out_if.block_end   = block_end_r;

  always_comb begin
    emittable     = (cnt_r >= CNT_W'(BYTE_W)) || (last_r && cnt_r != '0);
    slot_free     = !out_valid_r || out_if.ready;
    emit          = emittable && slot_free;
    pop           = !emittable && q_stat.nonempty;
    rem           = (cnt_r >= CNT_W'(BYTE_W)) ? cnt_r - CNT_W'(BYTE_W) : '0;
    rem_emittable = (rem >= CNT_W'(BYTE_W)) || (last_r && rem != '0);
    window        = {acc_r, {BYTE_W{1'b0}}} >> cnt_r;
    pend          = acc_r[PEND_W-1:0] & ((PEND_W'(1) << cnt_r[2:0]) - PEND_W'(1));

    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    run_end_nxt   = run_end_r;
    block_end_nxt = block_end_r;

    if (emit) begin
      cnt_nxt       = rem;
      out_valid_nxt = 1'b1;
      byte_nxt      = window[BYTE_W-1:0];
      run_end_nxt   = !rem_emittable;
      block_end_nxt = !rem_emittable && last_r;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (pop) begin
      acc_nxt  = (ACC_W'(pend) << q_data.cw_len) | ACC_W'(q_data.cw);
      cnt_nxt  = (last_r ? CNT_W'(0) : cnt_r) + CNT_W'(q_data.cw_len);
      last_nxt = q_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    byte_r      <= byte_nxt;
    run_end_r   <= run_end_nxt;
    block_end_r <= block_end_nxt;
  end

endmodule

// ===== design/lec_sample_encoder_packer.sv =====
// Lossless sample encoder with byte packer.
// in_if: one sensor sample per transfer (sample, last_sample), valid/ready.
// out_if: one byte per transfer (packed_byte, run_end, block_end), valid/ready.
// cfg_wr_en/cfg_wr_data: write the initial reference; write only while idle.
// Each sample is differenced against the previous one (first of a block
// against the reference), coded as LEC prefix plus suffix, and packed MSB
// first. last_sample flushes pending bits, zero padded, and restarts the block.
// The first byte of a sample passes the queue slot, the packer's accumulator
// and the output byte register before it is on out_if. A two-entry queue
// parts the coder from the packer; the packer takes a codeword only when it
// has no byte left to emit, so it emits each sample's bytes before it takes
// the next codeword. Samples keep being taken while the queue has room.
// Reset (rst_n low, synchronous) empties queue, pending bits and output
// register, clears the reference to zero and starts a new block.
// When the receiver stalls the output byte holds, the packer waits, and
// in_if.ready drops once the queue fills.
module lec_sample_encoder_packer #(
  parameter int SAMPLE_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lsep_in_if.sink                    in_if,
  lsep_out_if.source                 out_if,
  input  logic                       cfg_wr_en,
  input  logic [lsep_pkg::REF_W-1:0] cfg_wr_data
);
  import lsep_pkg::*;

  logic [REF_W-1:0] init_ref_r;
  logic             push;
  lsep_code_t       push_data;
  logic             pop;
  lsep_code_t       pop_data;
  lsep_q_stat_t     q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_ref_r <= '0;
    end else if (cfg_wr_en) begin
      init_ref_r <= cfg_wr_data;
    end
  end

  lsep_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_ref  (init_ref_r),
    .in_if     (in_if),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  lsep_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  lsep_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_data (pop_data),
    .pop    (pop),
    .out_if (out_if)
  );

  a_block_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.block_end |-> out_if.run_end)
    else $error("block_end without run_end");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.nonempty)
    else $error("queue read while empty");

endmodule
